/* src/dfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dfe_pkg;

  // Divider shape shared by the unit-vector and reciprocal dividers
  localparam int unsigned DivNumW = 60;
  localparam int unsigned DivDenW = 31;
  localparam int unsigned DivQuoW = 31;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [7:0]  NearSqLimit  = 8'd43;
  localparam logic [31:0] DipoleReset  = 32'h0000_0000;
  localparam logic [15:0] AxisReset    = 16'h0000;
  localparam logic [15:0] AxisZReset   = 16'hC000;
  localparam logic [31:0] MomentReset  = 32'h0001_0000;
  localparam logic [15:0] PpmReset     = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIPOLE_X,
    CFG_DIPOLE_Y,
    CFG_DIPOLE_Z,
    CFG_AXIS_X,
    CFG_AXIS_Y,
    CFG_AXIS_Z,
    CFG_MOMENT,
    CFG_PPM
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } dfe_point_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic               too_close;
    logic               clipped;
  } dfe_field_t;

endpackage

`default_nettype wire

/* src/dfe_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage, QuoW stages deep.
// Needs num_i < den_i * 2**QuoW.
module dfe_div import dfe_pkg::*; #(
  parameter int unsigned NumW = DivNumW,
  parameter int unsigned DenW = DivDenW,
  parameter int unsigned QuoW = DivQuoW
) (
  input  logic            clk_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  localparam int unsigned RemW = DenW + QuoW;

  logic [RemW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar g = 0; g < QuoW; g++) begin : g_step
    localparam int unsigned Bit = QuoW - 1 - g;
    logic [RemW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [RemW-1:0] trial;
    logic            ge;

    if (g == 0) begin : g_first
      assign rem_in = RemW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    assign trial = RemW'(den_in) << Bit;
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[g] <= ge ? rem_in - trial : rem_in;
      den_q[g] <= den_in;
      quo_q[g] <= ge ? (quo_in | (QuoW'(1) << Bit)) : quo_in;
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

`default_nettype wire

/* src/dipole_field_evaluator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Point-dipole field evaluator. Each accepted query point (start high, busy
// low) yields one field item on result_o, marked by result_valid_o for exactly
// one cycle. busy never rises: a new point may enter in every cycle, and up
// to 80 points are in flight at once. The depth of the pipeline is set by the
// 31-step digit-by-digit square root of |p - dipole|^2 followed by the 31-step
// restoring dividers that form the unit vector and
// 2^59/r; the rest is 18 short arithmetic stages (5 before the square root,
// 13 after the dividers). The receiver cannot hold results off, so nothing in
// the pipeline ever stalls. Configuration writes
// (cfg_valid_i/cfg_ready_o, ready always high) are taken at any time but must
// only be issued while no point is in flight, since later stages read the
// registers live. When |p - dipole| is below 0.0001 pixel the field is zero
// and too_close is set; saturated components set clipped.
module dipole_field_evaluator_unit import dfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  dfe_point_t         point_i,
  output logic               result_valid_o,
  output dfe_field_t         result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  // Stage bookkeeping: ranks count register stages after the accept edge.
  localparam int unsigned SqrtSteps = 31;
  localparam int unsigned PreLat    = 5;
  localparam int unsigned PostLat   = 13;
  localparam int unsigned PostBase  = PreLat + SqrtSteps + DivQuoW;
  localparam int unsigned Lat       = PostBase + PostLat;
  localparam int unsigned SideLen   = Lat - 3;
  localparam int unsigned AmagLen   = PreLat - 2 + SqrtSteps;
  localparam int unsigned RadW      = 2 * SqrtSteps;
  localparam logic [DivNumW-1:0] RecipNum = DivNumW'(1) << 59;

  // Per-item flags that ride alongside the arithmetic.
  typedef struct packed {
    logic       near;
    logic [2:0] neg;
    logic [5:0] len;
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] dipole_x_q, dipole_y_q, dipole_z_q, moment_q;
  logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;
  logic [15:0]        ppm_q;
  logic [31:0]        ppm2_q;
  logic [47:0]        ppm3_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dipole_x_q <= DipoleReset;
      dipole_y_q <= DipoleReset;
      dipole_z_q <= DipoleReset;
      axis_x_q   <= AxisReset;
      axis_y_q   <= AxisReset;
      axis_z_q   <= AxisZReset;
      moment_q   <= MomentReset;
      ppm_q      <= PpmReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIPOLE_X: dipole_x_q <= cfg_data_i;
        CFG_DIPOLE_Y: dipole_y_q <= cfg_data_i;
        CFG_DIPOLE_Z: dipole_z_q <= cfg_data_i;
        CFG_AXIS_X:   axis_x_q   <= cfg_data_i[15:0];
        CFG_AXIS_Y:   axis_y_q   <= cfg_data_i[15:0];
        CFG_AXIS_Z:   axis_z_q   <= cfg_data_i[15:0];
        CFG_MOMENT:   moment_q   <= cfg_data_i;
        CFG_PPM:      ppm_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ppm^3 is registered through ppm2_q and then ppm3_q, long before any item needs it.
  always_ff @(posedge clk_i) begin
    ppm2_q <= ppm_q * ppm_q;
    ppm3_q <= ppm2_q * ppm_q;
  end

  logic signed [31:0] pt  [3];
  logic signed [31:0] dip [3];
  logic signed [15:0] ax  [3];
  logic [31:0]        mmag;

  always_comb begin
    pt[0]  = point_i.point_x;
    pt[1]  = point_i.point_y;
    pt[2]  = point_i.point_z;
    dip[0] = dipole_x_q;
    dip[1] = dipole_y_q;
    dip[2] = dipole_z_q;
    ax[0]  = axis_x_q;
    ax[1]  = axis_y_q;
    ax[2]  = axis_z_q;
    mmag   = moment_q[31] ? 32'(-moment_q) : 32'(moment_q);
  end

  // ---------------------------------------------------------------------------
  // Valid line: one bit per rank, no stalls
  // ---------------------------------------------------------------------------
  logic [Lat-1:0] vld_q, vld_d;

  assign vld_d = {vld_q[Lat-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign result_valid_o = vld_q[Lat-1];

  // ---------------------------------------------------------------------------
  // Rank 1: offset from dipole center, 33 bits
  // ---------------------------------------------------------------------------
  logic signed [32:0] diff_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      diff_q[i] <= 33'(pt[i]) - 33'(dip[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // Rank 2: magnitudes, common bit length, near test
  // ---------------------------------------------------------------------------
  logic [32:0] mag_d [3];
  logic [32:0] mag_or;
  logic [5:0]  len_d;
  logic [7:0]  sq_sum;
  logic        all_low;
  logic        near_d;

  always_comb begin
    sq_sum  = '0;
    all_low = 1'b1;
    len_d   = '0;
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = diff_q[i][32] ? 33'(-diff_q[i]) : 33'(diff_q[i]);
      if (mag_d[i][32:3] != '0 || mag_d[i][2:0] == 3'd7) all_low = 1'b0;
      sq_sum = sq_sum + ({5'b0, mag_d[i][2:0]} * {5'b0, mag_d[i][2:0]});
    end
    // bit length of the largest magnitude equals that of the OR
    mag_or = mag_d[0] | mag_d[1] | mag_d[2];
    for (int b = 0; b < 33; b++) begin
      if (mag_or[b]) len_d = 6'(b + 1);
    end
    near_d = all_low && (sq_sum < NearSqLimit);
  end

  logic [32:0] mag2_q [3];
  logic [2:0]  neg2_q;
  logic [5:0]  len2_q;
  logic        near2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mag2_q[i] <= mag_d[i];
      neg2_q[i] <= diff_q[i][32];
    end
    len2_q  <= len_d;
    near2_q <= near_d;
  end

  // ---------------------------------------------------------------------------
  // Rank 3: normalize so the largest component lands in [2^29, 2^30)
  // ---------------------------------------------------------------------------
  logic [2:0][29:0] amag_d;
  logic [2:0][29:0] amag_q [AmagLen];
  side_t            side_q [SideLen];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag_d[i] = 30'({mag2_q[i], 30'b0} >> len2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    amag_q[0] <= amag_d;
    side_q[0] <= '{near: near2_q, neg: neg2_q, len: len2_q};
    for (int j = 1; j < AmagLen; j++) amag_q[j] <= amag_q[j-1];
    for (int j = 1; j < SideLen; j++) side_q[j] <= side_q[j-1];
  end

  // ---------------------------------------------------------------------------
  // Ranks 4-5: squared length
  // ---------------------------------------------------------------------------
  logic [59:0]     sq_q [3];
  logic [RadW-1:0] n2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= amag_q[0][i] * amag_q[0][i];
    end
    n2_q <= RadW'(sq_q[0]) + RadW'(sq_q[1]) + RadW'(sq_q[2]);
  end

  // ---------------------------------------------------------------------------
  // Ranks 6-36: floor square root, one root bit per stage
  // ---------------------------------------------------------------------------
  logic [RadW-1:0]      srem_q  [SqrtSteps];
  logic [SqrtSteps-1:0] sroot_q [SqrtSteps];

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    localparam int unsigned Bit = SqrtSteps - 1 - g;
    logic [RadW-1:0]      rin;
    logic [SqrtSteps-1:0] oin;
    logic [RadW:0]        trial;
    logic                 ge;

    if (g == 0) begin : g_first
      assign rin = n2_q;
      assign oin = '0;
    end else begin : g_next
      assign rin = srem_q[g-1];
      assign oin = sroot_q[g-1];
    end

    // (R + 2^b)^2 - R^2 = R*2^(b+1) + 2^(2b)
    assign trial = ((RadW+1)'(oin) << (Bit + 1)) + ((RadW+1)'(1) << (2 * Bit));
    assign ge    = {1'b0, rin} >= trial;

    always_ff @(posedge clk_i) begin
      srem_q[g]  <= ge ? rin - trial[RadW-1:0] : rin;
      sroot_q[g] <= ge ? (oin | (SqrtSteps'(1) << Bit)) : oin;
    end
  end

  // ---------------------------------------------------------------------------
  // Ranks 37-67: unit vector |a|*2^30/r and reciprocal 2^59/r
  // ---------------------------------------------------------------------------
  logic [DivQuoW-1:0] umag [3];
  logic [DivQuoW-1:0] recip;

  for (genvar i = 0; i < 3; i++) begin : g_udiv
    dfe_div #(
      .NumW (DivNumW),
      .DenW (DivDenW),
      .QuoW (DivQuoW)
    ) u_div (
      .clk_i (clk_i),
      .num_i ({amag_q[AmagLen-1][i], 30'b0}),
      .den_i (sroot_q[SqrtSteps-1]),
      .quo_o (umag[i])
    );
  end

  dfe_div #(
    .NumW (DivNumW),
    .DenW (DivDenW),
    .QuoW (DivQuoW)
  ) u_recip (
    .clk_i (clk_i),
    .num_i (RecipNum),
    .den_i (sroot_q[SqrtSteps-1]),
    .quo_o (recip)
  );

  // ---------------------------------------------------------------------------
  // Ranks 68-80: cos(theta), 1/r^3 scale, product, shift, saturate
  // ---------------------------------------------------------------------------
  logic signed [31:0] usig1_q [3], usig2_q [3], usig3_q [3], usig4_q [3];
  logic [30:0]        f1_q, f1b_q, f2_q, f3_q;
  logic signed [47:0] dotp2_q [3];
  logic signed [49:0] dot3_q;
  logic signed [23:0] c3_4_q;
  logic [62:0]        plo4_q;
  logic [46:0]        phi4_q;
  logic signed [55:0] cu5_q [3];
  logic [78:0]        prod5_q, prod6_q;
  logic signed [35:0] v6_q [3];
  logic [5:0]         t6_q;
  logic [31:0]        q7_q;
  logic [34:0]        vmag7_q [3], vmag8_q [3];
  logic [2:0]         vneg7_q, vneg8_q, vneg9_q, vneg10_q, vneg11_q, vneg12_q;
  logic [7:0]         n7_q, n8_q, n9_q, n10_q;
  logic [3:0]         n11_q;
  logic [63:0]        s8_q;
  logic [66:0]        pl9_q [3], ph9_q [3];
  logic [98:0]        pp10_q [3];
  logic [127:0]       w11_q [3], w12_q [3];

  logic [61:0] ff_prod, fff_prod;
  logic [6:0]  blen;
  logic [5:0]  t_d;
  logic [8:0]  n_d;
  side_t       side_p1, side_p7, side_p13;

  always_comb begin
    side_p1  = side_q[PostBase + 1 - 4];
    side_p7  = side_q[PostBase + 7 - 4];
    side_p13 = side_q[PostBase + 13 - 4];
    ff_prod  = f1_q * f1_q;
    fff_prod = f2_q * f1b_q;
    blen     = '0;
    for (int b = 0; b < 79; b++) begin
      if (prod5_q[b]) blen = 7'(b + 1);
    end
    // least right shift that brings the scale product below 2^32
    t_d = (blen > 7'd32) ? 6'(blen - 7'd32) : 6'd0;
    // total right shift of s*|v| placed at the top of a 128-bit window
    n_d = 9'd38 + 9'(side_p7.len) + 9'(side_p7.len) + 9'(side_p7.len) - 9'(t6_q);
  end

  always_ff @(posedge clk_i) begin
    // p1
    for (int i = 0; i < 3; i++) begin
      usig1_q[i] <= side_p1.neg[i] ? -32'(umag[i]) : 32'(umag[i]);
    end
    f1_q <= recip;
    // p2
    for (int i = 0; i < 3; i++) begin
      dotp2_q[i] <= usig1_q[i] * ax[i];
    end
    usig2_q <= usig1_q;
    f2_q    <= ff_prod[60:30];
    f1b_q   <= f1_q;
    // p3
    dot3_q  <= 50'(dotp2_q[0]) + 50'(dotp2_q[1]) + 50'(dotp2_q[2]);
    f3_q    <= fff_prod[60:30];
    usig3_q <= usig2_q;
    // p4: 3 * floor(dot / 2^28)
    c3_4_q  <= 24'(3 * (dot3_q >>> 28));
    plo4_q  <= f3_q * ppm3_q[31:0];
    phi4_q  <= f3_q * ppm3_q[47:32];
    usig4_q <= usig3_q;
    // p5
    for (int i = 0; i < 3; i++) begin
      cu5_q[i] <= c3_4_q * usig4_q[i];
    end
    prod5_q <= 79'(plo4_q) + (79'(phi4_q) << 32);
    // p6: v = 3 c u - d, Q.30
    for (int i = 0; i < 3; i++) begin
      v6_q[i] <= 36'(cu5_q[i] >>> 16) - (36'(ax[i]) <<< 16);
    end
    t6_q    <= t_d;
    prod6_q <= prod5_q;
    // p7
    q7_q <= 32'(prod6_q >> t6_q);
    for (int i = 0; i < 3; i++) begin
      vmag7_q[i] <= v6_q[i][35] ? 35'(-v6_q[i]) : 35'(v6_q[i]);
      vneg7_q[i] <= v6_q[i][35] ^ moment_q[31];
    end
    n7_q <= n_d[7:0];
    // p8
    s8_q    <= q7_q * mmag;
    vmag8_q <= vmag7_q;
    vneg8_q <= vneg7_q;
    n8_q    <= n7_q;
    // p9: split 64 x 35 product into two halves
    for (int i = 0; i < 3; i++) begin
      pl9_q[i] <= s8_q[31:0] * vmag8_q[i];
      ph9_q[i] <= s8_q[63:32] * vmag8_q[i];
    end
    vneg9_q <= vneg8_q;
    n9_q    <= n8_q;
    // p10
    for (int i = 0; i < 3; i++) begin
      pp10_q[i] <= 99'(pl9_q[i]) + (99'(ph9_q[i]) << 32);
    end
    vneg10_q <= vneg9_q;
    n10_q    <= n9_q;
    // p11: coarse shift by multiples of 16
    for (int i = 0; i < 3; i++) begin
      w11_q[i] <= {pp10_q[i], 29'b0} >> {n10_q[7:4], 4'b0};
    end
    vneg11_q <= vneg10_q;
    n11_q    <= n10_q[3:0];
    // p12: fine shift
    for (int i = 0; i < 3; i++) begin
      w12_q[i] <= w11_q[i] >> n11_q;
    end
    vneg12_q <= vneg11_q;
  end

  // p13: saturate and sign
  logic [31:0] fld   [3];
  logic [2:0]  clip;
  logic [31:0] limit;
  logic [31:0] magc;
  dfe_field_t  result_d, result_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      limit   = vneg12_q[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      clip[i] = (w12_q[i][127:32] != '0) || (w12_q[i][31:0] > limit);
      magc    = clip[i] ? limit : w12_q[i][31:0];
      fld[i]  = vneg12_q[i] ? 32'(-magc) : magc;
    end
    if (side_p13.near) begin
      result_d = '{field_x: '0, field_y: '0, field_z: '0, too_close: 1'b1, clipped: 1'b0};
    end else begin
      result_d = '{field_x: fld[0], field_y: fld[1], field_z: fld[2],
                   too_close: 1'b0, clipped: |clip};
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

/* test/tb_dipole_field_evaluator_unit.sv */
`timescale 1ns / 1ps

module tb_dipole_field_evaluator_unit;
  import dfe_pkg::*;

  localparam int unsigned PipeLatency = 80;
  localparam int unsigned DrainWait   = PipeLatency + 20;
  localparam int unsigned QuietLimit  = 4000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  dfe_point_t point_i = '0;
  logic       result_valid_o;
  dfe_field_t result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  dipole_field_evaluator_unit u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .point_i,
    .result_valid_o,
    .result_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the dipole registers, updated on each accepted write.
  logic [31:0] dipole_pos[3];
  logic [15:0] dipole_axis[3];
  logic [31:0] dipole_moment;
  logic [15:0] ppm_scale;

  dfe_field_t  fields_due[$];
  int unsigned mismatches = 0;
  int unsigned points_sent = 0;
  int unsigned fields_seen = 0;
  int unsigned near_seen = 0;
  int unsigned clip_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;
  bit          no_gaps = 1'b0;

  function automatic logic [63:0] abs_val(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale s*|v| by 2^e, saturate to 32 bits, apply sign.
  function automatic logic [31:0] scale_sat(input logic [63:0] s, input longint v,
                                            input bit neg_m, input int e, inout bit clip);
    logic [127:0] wide;
    logic [63:0]  mg;
    logic [63:0]  limit;
    bit           neg;
    neg = neg_m != (v < 0);
    limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    wide = 128'(s) * 128'(abs_val(v));
    if (e < 0) wide = (-e >= 128) ? '0 : wide >> (-e);
    mg = wide[63:0];
    if (wide[127:64] != 0) mg = limit + 1;
    if (e > 0 && mg != 0) begin
      if (e >= 32 || mg > (limit >> e)) mg = limit + 1;
      else mg = mg << e;
    end
    if (mg > limit) begin
      mg = limit;
      clip = 1'b1;
    end
    if (neg) mg = ~mg + 64'd1;
    return mg[31:0];
  endfunction

  // Field of the shadow dipole at point p.
  function automatic dfe_field_t dipole_field(dfe_point_t p);
    longint       diff[3], scl[3], unit[3], vec[3], ax_s[3];
    longint       dotp, cosq, mom_s;
    logic [63:0]  maxa, sumsq, root, mg, recip, rec2, rec3, ppm3, q, s;
    logic [127:0] wide;
    logic [31:0]  comp[3];
    int           blen, k, t;
    bit           near, clip;
    dfe_field_t   res;
    res = '0;
    diff[0] = longint'(p.point_x) - longint'($signed(dipole_pos[0]));
    diff[1] = longint'(p.point_y) - longint'($signed(dipole_pos[1]));
    diff[2] = longint'(p.point_z) - longint'($signed(dipole_pos[2]));
    for (int i = 0; i < 3; i++) ax_s[i] = longint'($signed(dipole_axis[i]));
    mom_s = longint'($signed(dipole_moment));
    near = 1'b1;
    clip = 1'b0;
    sumsq = '0;
    maxa = '0;
    for (int i = 0; i < 3; i++) begin
      mg = abs_val(diff[i]);
      if (mg > maxa) maxa = mg;
      if (mg > 6) near = 1'b0;
      else sumsq = sumsq + mg * mg;
    end
    if (near && sumsq < 64'(NearSqLimit)) begin
      res.too_close = 1'b1;
      return res;
    end
    // normalize the largest component to 30 bits
    blen = 0;
    while (blen < 64 && (maxa >> blen) != 0) blen++;
    k = 30 - blen;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      if (k >= 0) begin
        scl[i] = diff[i] <<< k;
      end else begin
        mg = abs_val(diff[i]) >> (-k);
        scl[i] = (diff[i] < 0) ? -longint'(mg) : longint'(mg);
      end
      sumsq = sumsq + abs_val(scl[i]) * abs_val(scl[i]);
    end
    root = int_sqrt(sumsq);
    dotp = 0;
    for (int i = 0; i < 3; i++) begin
      mg = (abs_val(scl[i]) << 30) / root;
      unit[i] = (scl[i] < 0) ? -longint'(mg) : longint'(mg);
      dotp = dotp + unit[i] * ax_s[i];
    end
    cosq = dotp >>> 28;
    for (int i = 0; i < 3; i++)
      vec[i] = ((3 * cosq * unit[i]) >>> 16) - ax_s[i] * 65536;
    recip = 64'h0800_0000_0000_0000 / root;
    rec2 = (recip * recip) >> 30;
    rec3 = (rec2 * recip) >> 30;
    ppm3 = 64'(ppm_scale) * 64'(ppm_scale) * 64'(ppm_scale);
    wide = 128'(ppm3) * 128'(rec3);
    t = 0;
    while ((wide >> 32) != 0) begin
      wide = wide >> 1;
      t++;
    end
    q = wide[63:0];
    s = q * abs_val(mom_s);
    for (int i = 0; i < 3; i++)
      comp[i] = scale_sat(s, vec[i], mom_s < 0, 3 * k - 99 + t, clip);
    res.field_x = comp[0];
    res.field_y = comp[1];
    res.field_z = comp[2];
    res.clipped = clip;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Results: compare each strobed item with the oldest expected field.
  always @(posedge clk_i) begin
    dfe_field_t want;
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (result_valid_o) begin
        fields_seen++;
        if (fields_due.size() == 0) begin
          $display("[%0t] field item with nothing outstanding", $realtime);
          mismatches++;
        end else begin
          want = fields_due.pop_front();
          if (want.too_close) near_seen++;
          if (want.clipped) clip_seen++;
          if (result_o.field_x !== want.field_x)
            report_mismatch("field_x", result_o.field_x, want.field_x);
          if (result_o.field_y !== want.field_y)
            report_mismatch("field_y", result_o.field_y, want.field_y);
          if (result_o.field_z !== want.field_z)
            report_mismatch("field_z", result_o.field_z, want.field_z);
          if (result_o.too_close !== want.too_close)
            report_mismatch("too_close", 32'(result_o.too_close), 32'(want.too_close));
          if (result_o.clipped !== want.clipped)
            report_mismatch("clipped", 32'(result_o.clipped), 32'(want.clipped));
        end
      end
    end
  end

  // Watchdog: too long without any handshake or result means a hang.
  always @(posedge clk_i) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One register write; the handshake decides the edge, shadow follows it.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    case (idx)
      CFG_DIPOLE_X: dipole_pos[0] = value;
      CFG_DIPOLE_Y: dipole_pos[1] = value;
      CFG_DIPOLE_Z: dipole_pos[2] = value;
      CFG_AXIS_X:   dipole_axis[0] = value[15:0];
      CFG_AXIS_Y:   dipole_axis[1] = value[15:0];
      CFG_AXIS_Z:   dipole_axis[2] = value[15:0];
      CFG_MOMENT:   dipole_moment = value;
      CFG_PPM:      ppm_scale = value[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_dipole(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                            logic [31:0] mom, logic [15:0] ppm);
    write_reg(CFG_DIPOLE_X, px);
    write_reg(CFG_DIPOLE_Y, py);
    write_reg(CFG_DIPOLE_Z, pz);
    write_reg(CFG_AXIS_X, 32'(dx));
    write_reg(CFG_AXIS_Y, 32'(dy));
    write_reg(CFG_AXIS_Z, 32'(dz));
    write_reg(CFG_MOMENT, mom);
    write_reg(CFG_PPM, 32'(ppm));
  endtask

  // Wait until every field is back, then let the pipe drain before reconfig.
  task automatic wait_idle();
    while (fields_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Send one point item. start stays high when no gap follows, so
  // back-to-back items never lower and raise start in the same step.
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    dfe_point_t  p;
    int unsigned gap;
    p.point_x = px;
    p.point_y = py;
    p.point_z = pz;
    @(negedge clk_i);
    start   <= 1'b1;
    point_i <= p;
    while (busy) @(negedge clk_i);
    // busy is low at this falling edge: the next rising edge takes the item
    @(posedge clk_i);
    fields_due = {fields_due, dipole_field(p)};
    points_sent++;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Points right at the dipole: near-field cutoff edges around r^2 = 43.
  task automatic test_near_cutoff();
    set_dipole(32'h0001_2345, 32'hFFFE_0000, 32'h0000_0010,
               16'h0000, 16'h0000, 16'hC000, 32'h0001_0000, 16'd100);
    send_point(32'h0001_2345, 32'hFFFE_0000, 32'h0000_0010);   // r = 0
    send_point(32'h0001_2345 + 6, 32'hFFFE_0000 + 1, 32'h0000_0010 + 1);
    send_point(32'h0001_2345 + 6, 32'hFFFE_0000 + 2, 32'h0000_0010 + 2);
    send_point(32'h0001_2345 - 5, 32'hFFFE_0000 - 3, 32'h0000_0010 + 3);
    send_point(32'h0001_2345 + 4, 32'hFFFE_0000 - 3, 32'h0000_0010 - 4);
    send_point(32'h0001_2345 + 7, 32'hFFFE_0000, 32'h0000_0010);
    send_point(32'h0001_2345, 32'hFFFE_0000 - 7, 32'h0000_0010);
    end_burst();
    wait_idle();
  endtask

  // Field extremes: largest offsets, tiny offsets with huge moment, zero scale.
  task automatic test_extremes();
    set_dipole(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               16'h4000, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 16'd65535);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000 + 7, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h8000_0000 + 100, 32'h8000_0000 + 3);
    end_burst();
    wait_idle();
    set_dipole(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000,
               16'hC000, 16'h4000, 16'hC000, 32'h8000_0000, 16'd1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF - 9, 32'h0000_0004, 32'h8000_0000 + 1);
    send_point(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    end_burst();
    wait_idle();
    // zero scale and an axis that is not unit length
    set_dipole(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
               16'h7FFF, 16'h8000, 16'h2D41, 32'hFFFF_0000, 16'd0);
    send_point(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000);
    end_burst();
    wait_idle();
    write_reg(CFG_PPM, 32'd1000);
    send_point(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_point(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000);
    end_burst();
    wait_idle();
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0:       return 16'h4000;
      1:       return 16'hC000;
      2:       return 16'h0000;
      3:       return 16'($urandom);     // raw, not unit length
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] near_coord(logic [31:0] base);
    int unsigned span;
    span = $urandom_range(0, 24);
    return base + 32'($signed($urandom_range(0, (2 << span))) - (1 << span));
  endfunction

  // Random phases: fresh dipole setup, then a burst of points around it.
  task automatic test_random_phases(int unsigned phases, int unsigned per_phase);
    logic [31:0] px, py, pz, mom;
    logic [15:0] ppm;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 4))
        0:       mom = 32'h7FFF_FFFF;
        1:       mom = 32'h8000_0000;
        2:       mom = $urandom;
        default: mom = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
      endcase
      case ($urandom_range(0, 4))
        0:       ppm = 16'd1;
        1:       ppm = 16'hFFFF;
        2:       ppm = 16'($urandom);
        default: ppm = 16'($urandom_range(1, 400));
      endcase
      set_dipole((ph % 3 == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000),
                 $urandom, $urandom, pick_axis(), pick_axis(), pick_axis(), mom, ppm);
      no_gaps = (ph % 4 == 1);
      for (int n = 0; n < per_phase; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            px = $urandom;
            py = $urandom;
            pz = $urandom;
          end
          7: begin
            px = dipole_pos[0] + 32'($signed($urandom_range(0, 16)) - 8);
            py = dipole_pos[1] + 32'($signed($urandom_range(0, 16)) - 8);
            pz = dipole_pos[2] + 32'($signed($urandom_range(0, 16)) - 8);
          end
          default: begin
            px = near_coord(dipole_pos[0]);
            py = near_coord(dipole_pos[1]);
            pz = near_coord(dipole_pos[2]);
          end
        endcase
        send_point(px, py, pz);
      end
      end_burst();
      wait_idle();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    dipole_pos[0] = DipoleReset;
    dipole_pos[1] = DipoleReset;
    dipole_pos[2] = DipoleReset;
    dipole_axis[0] = AxisReset;
    dipole_axis[1] = AxisReset;
    dipole_axis[2] = AxisZReset;
    dipole_moment = MomentReset;
    ppm_scale = PpmReset;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset values: points around the origin with the default dipole
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_point(32'h0005_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(32'hFFFE_8000, 32'h0003_0000, 32'hFFFF_0000);
    end_burst();
    wait_idle();

    test_near_cutoff();
    test_extremes();
    test_random_phases(14, 124);

    repeat (DrainWait) @(posedge clk_i);
    $display("Covered %0d points (%0d near cutoff, %0d saturated), %0d register writes",
             points_sent, near_seen, clip_seen, cfg_writes);
    $display("Field items checked: %0d, mismatches: %0d", fields_seen, mismatches);
    if (mismatches == 0 && fields_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* dipole_field_evaluator_unit.f */
src/dfe_pkg.sv
src/dfe_div.sv
src/dipole_field_evaluator_unit.sv
test/tb_dipole_field_evaluator_unit.sv
